// ===== rtl/cqs_pkg.sv =====
// Shared types and constants for the circular queue with search.
`default_nettype none

package cqs_pkg;

    localparam int DEPTH_DEF  = 8;
    localparam int WORD_W     = 32;
    localparam int POS_W      = 4;
    localparam int CMD_W      = 2;
    localparam int STATUS_W   = 3;
    localparam int OUT_TDATA_W = 40;
    localparam int OUT_PAD_W  = OUT_TDATA_W - WORD_W - POS_W;

    typedef logic signed [WORD_W-1:0] word_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_ENQ     = 2'd0,
        CMD_DEQ     = 2'd1,
        CMD_DISPLAY = 2'd2,
        CMD_SEARCH  = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_ENQUEUED  = 3'd0,
        ST_FULL      = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_FOUND     = 3'd3,
        ST_NOT_FOUND = 3'd4,
        ST_WORD      = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECIDE,
        S_WALK
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic    load;        // capture input beat
        logic    enq;         // write slot at tail, bump occupancy
        logic    walk_init;   // set up read walk for dequeue/display/search
        logic    fetch;       // read one slot into the read register
        logic    consume;     // read register taken this cycle
        logic    pop;         // dequeue completes
        logic    emit;        // load result register
        status_t emit_status;
        logic    emit_word;   // value from read register
        logic    emit_pos;    // position from read slot
        logic    emit_last;
    } ctl_t;

    // datapath -> controller
    typedef struct packed {
        cmd_t cmd;
        logic empty;
        logic full;
        logic pend;        // read register holds an unconsumed entry
        logic pend_last;   // that entry is the final one of the walk
        logic match;       // read entry equals search key
        logic fetch_done;  // all entries of the walk issued
        logic out_free;    // result register can take a beat
    } sts_t;

endpackage

`default_nettype wire

// ===== rtl/circular_queue_with_search_core.sv =====
// Top level of the circular queue with search: controller plus datapath.
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+-----------------------------------------
//  s_*      | in  | s_tvalid/s_tready  | tdata: data; tuser: command
//  m_*      | out | m_tvalid/m_tready  | tdata: value, position; tuser: status;
//           |     |                    | tlast: last
//
// Enqueue, or any command on an empty queue, loads its result from the decode state. A dequeue,
// display or search sets up the read walk, then the single read port of the slot memory gives
// one entry per cycle while the result register is free. One item at a time; s_tready is high
// while the controller is idle, also while a result still waits in the output register. While
// a result waits and m_tready is low, a walk stops once its read register holds an entry.
// rst_n clears pointers, occupancy and control; the slot memory is not cleared.
`default_nettype none

module circular_queue_with_search_core #(
    parameter int DEPTH = cqs_pkg::DEPTH_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [cqs_pkg::WORD_W-1:0]          s_tdata,   // [31:0] data
    input  wire logic [cqs_pkg::CMD_W-1:0]           s_tuser,   // [1:0] command
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [cqs_pkg::OUT_TDATA_W-1:0]          m_tdata,   // [31:0] value, [35:32] position
    output logic [cqs_pkg::STATUS_W-1:0]             m_tuser,   // [2:0] status
    output logic                                     m_tlast
);
    import cqs_pkg::*;

    ctl_t ctl;
    sts_t sts;

    cqs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .ctl      (ctl)
    );

    cqs_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (s_tdata),
        .in_cmd   (s_tuser),
        .ctl      (ctl),
        .sts      (sts),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

// ===== rtl/cqs_ctrl.sv =====
// Controller state machine for the circular queue with search.
`default_nettype none

module cqs_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire cqs_pkg::sts_t sts,
    output cqs_pkg::ctl_t      ctl
);
    import cqs_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   walk_finish;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // taken read entry ends the item on dequeue, last entry or match
    always_comb
    begin
        walk_finish = sts.pend && sts.out_free &&
                      (sts.cmd == CMD_DEQ || sts.pend_last ||
                       (sts.cmd == CMD_SEARCH && sts.match));
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (sts.cmd == CMD_ENQ || sts.empty)
                begin
                    if (sts.out_free)
                    begin
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                if (walk_finish)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctl             = '0;
        ctl.emit_status = ST_ENQUEUED;
        s_tready        = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                ctl.load = s_tvalid;
            end
            S_DECIDE:
            begin
                if (sts.cmd == CMD_ENQ)
                begin
                    if (sts.out_free)
                    begin
                        ctl.emit      = 1'b1;
                        ctl.emit_last = 1'b1;
                        if (sts.full)
                        begin
                            ctl.emit_status = ST_FULL;
                        end
                        else
                        begin
                            ctl.enq         = 1'b1;
                            ctl.emit_status = ST_ENQUEUED;
                        end
                    end
                end
                else if (sts.empty)
                begin
                    if (sts.out_free)
                    begin
                        ctl.emit        = 1'b1;
                        ctl.emit_last   = 1'b1;
                        ctl.emit_status = (sts.cmd == CMD_SEARCH) ? ST_NOT_FOUND : ST_EMPTY;
                    end
                end
                else
                begin
                    ctl.walk_init = 1'b1;
                end
            end
            S_WALK:
            begin
                ctl.fetch   = !sts.fetch_done && (!sts.pend || sts.out_free);
                ctl.consume = sts.pend && sts.out_free;
                if (ctl.consume)
                begin
                    unique case (sts.cmd)
                        CMD_DISPLAY:
                        begin
                            ctl.emit        = 1'b1;
                            ctl.emit_status = ST_WORD;
                            ctl.emit_word   = 1'b1;
                            ctl.emit_last   = sts.pend_last;
                        end
                        CMD_DEQ:
                        begin
                            ctl.emit        = 1'b1;
                            ctl.emit_status = ST_WORD;
                            ctl.emit_word   = 1'b1;
                            ctl.emit_last   = 1'b1;
                            ctl.pop         = 1'b1;
                        end
                        CMD_SEARCH:
                        begin
                            if (sts.match)
                            begin
                                ctl.emit        = 1'b1;
                                ctl.emit_status = ST_FOUND;
                                ctl.emit_pos    = 1'b1;
                                ctl.emit_last   = 1'b1;
                            end
                            else if (sts.pend_last)
                            begin
                                ctl.emit        = 1'b1;
                                ctl.emit_status = ST_NOT_FOUND;
                                ctl.emit_last   = 1'b1;
                            end
                        end
                        CMD_ENQ:
                        begin
                            ctl.emit = 1'b0;
                        end
                        default:
                        begin
                            ctl.emit = 1'b0;
                        end
                    endcase
                end
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    cqs_emit_free_chk: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.emit |-> sts.out_free)
        else $error("result loaded while result register busy");

    cqs_walk_entry_chk: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.walk_init |-> (!sts.empty && sts.cmd != CMD_ENQ))
        else $error("walk started on empty queue or for enqueue");

    cqs_accept_chk: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> state_reg == S_DECIDE)
        else $error("accepted beat not decoded");

endmodule

`default_nettype wire

// ===== rtl/cqs_dpath.sv =====
// Datapath: slot memory, ring pointers, read walk and result register.
`default_nettype none

module cqs_dpath #(
    parameter int DEPTH = cqs_pkg::DEPTH_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic [cqs_pkg::WORD_W-1:0]      in_data,
    input  wire logic [cqs_pkg::CMD_W-1:0]       in_cmd,
    input  wire cqs_pkg::ctl_t                   ctl,
    output cqs_pkg::sts_t                        sts,
    input  wire logic                            m_tready,
    output logic                                 m_tvalid,
    output logic [cqs_pkg::OUT_TDATA_W-1:0]      m_tdata,
    output logic [cqs_pkg::STATUS_W-1:0]         m_tuser,
    output logic                                 m_tlast
);
    import cqs_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    word_t   mem [DEPTH];

    cmd_t    cmd_reg;
    word_t   key_reg;
    logic [AW-1:0] head_reg;
    logic [AW-1:0] tail_reg;
    logic [CW-1:0] occ_reg;
    logic [AW-1:0] ptr_reg;
    logic [CW-1:0] fcnt_reg;
    logic [CW-1:0] len_reg;
    logic          pend_reg;
    word_t         rd_data_reg;
    logic [AW-1:0] rd_slot_reg;
    logic          rd_last_reg;

    logic          m_valid_reg;
    status_t       m_status_reg;
    word_t         m_value_reg;
    logic [POS_W-1:0] m_pos_reg;
    logic          m_last_reg;

    logic [AW-1:0] tail_prev;
    logic [AW-1:0] ptr_step;
    logic [AW-1:0] head_step;
    logic [AW-1:0] tail_step;
    logic [AW:0]   pos_full;
    logic          out_free;

    always_comb
    begin
        tail_prev = (tail_reg == '0) ? AW'(DEPTH - 1) : tail_reg - AW'(1);
        tail_step = (tail_reg == AW'(DEPTH - 1)) ? '0 : tail_reg + AW'(1);
        head_step = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + AW'(1);
        // display walks newest to oldest, the others oldest to newest
        if (cmd_reg == CMD_DISPLAY)
        begin
            ptr_step = (ptr_reg == '0) ? AW'(DEPTH - 1) : ptr_reg - AW'(1);
        end
        else
        begin
            ptr_step = (ptr_reg == AW'(DEPTH - 1)) ? '0 : ptr_reg + AW'(1);
        end
        pos_full = {1'b0, rd_slot_reg} + (AW + 1)'(1);
        out_free = !m_valid_reg || m_tready;
    end

    always_comb
    begin
        sts.cmd        = cmd_reg;
        sts.empty      = (occ_reg == '0);
        sts.full       = (occ_reg == CW'(DEPTH));
        sts.pend       = pend_reg;
        sts.pend_last  = rd_last_reg;
        sts.match      = (rd_data_reg == key_reg);
        sts.fetch_done = (fcnt_reg == len_reg);
        sts.out_free   = out_free;
    end

    // slot memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (ctl.enq)
        begin
            mem[tail_reg] <= key_reg;
        end
        if (ctl.fetch)
        begin
            rd_data_reg <= mem[ptr_reg];
            rd_slot_reg <= ptr_reg;
            rd_last_reg <= (fcnt_reg + CW'(1) == len_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg <= cmd_t'(in_cmd);
            key_reg <= word_t'(in_data);
        end
        if (ctl.walk_init)
        begin
            len_reg <= (cmd_reg == CMD_DEQ) ? CW'(1) : occ_reg;
        end
        if (ctl.emit)
        begin
            m_status_reg <= ctl.emit_status;
            m_value_reg  <= ctl.emit_word ? rd_data_reg : '0;
            m_pos_reg    <= ctl.emit_pos ? POS_W'(pos_full) : '0;
            m_last_reg   <= ctl.emit_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg    <= '0;
            tail_reg    <= '0;
            occ_reg     <= '0;
            ptr_reg     <= '0;
            fcnt_reg    <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.enq)
            begin
                tail_reg <= tail_step;
                occ_reg  <= occ_reg + CW'(1);
            end
            else if (ctl.pop)
            begin
                occ_reg <= occ_reg - CW'(1);
                if (occ_reg == CW'(1))
                begin
                    head_reg <= '0;
                    tail_reg <= '0;
                end
                else
                begin
                    head_reg <= head_step;
                end
            end

            if (ctl.walk_init)
            begin
                ptr_reg  <= (cmd_reg == CMD_DISPLAY) ? tail_prev : head_reg;
                fcnt_reg <= '0;
                pend_reg <= 1'b0;
            end
            else if (ctl.fetch)
            begin
                ptr_reg  <= ptr_step;
                fcnt_reg <= fcnt_reg + CW'(1);
                pend_reg <= 1'b1;
            end
            else if (ctl.consume)
            begin
                pend_reg <= 1'b0;
            end

            if (ctl.emit)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{OUT_PAD_W{1'b0}}, m_pos_reg, m_value_reg};
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;

    cqs_occ_range_chk: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CW'(DEPTH))
        else $error("occupancy beyond depth");

    cqs_empty_ptr_chk: assert property (@(posedge clk) disable iff (!rst_n)
        (occ_reg == '0) |-> (head_reg == '0 && tail_reg == '0))
        else $error("empty queue with pointers off slot zero");

    cqs_enq_count_chk: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.enq |=> occ_reg == $past(occ_reg) + CW'(1))
        else $error("enqueue did not raise occupancy");

    cqs_fetch_bound_chk: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.fetch |-> (fcnt_reg != len_reg && !ctl.walk_init))
        else $error("read issued past end of walk");

endmodule

`default_nettype wire
